/* sv/mer_pkg.sv */
// Shared types and constants of the midpoint ellipse rasterizer.
// Used by mer_setup and midpoint_ellipse_rasterizer_unit; depends on nothing.
package mer_pkg;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned SQ_W    = 16;
  localparam int unsigned TWICE_W = 18;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned SPAN_W  = 9;
  localparam int unsigned QUAD_W  = 4;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // Item kinds carried in the input tuser bit.
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOAD,
    ST_STEP_A,
    ST_STEP_B,
    ST_STEP_C,
    ST_STEP_D,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_RX_SQ,
    MS_RY_SQ,
    MS_STOP_X,
    MS_X_CHANGE,
    MS_Y_CHANGE,
    MS_STOP_Y
  } mul_step_t;

  // Products worked out once per ellipse for the start of both regions.
  typedef struct packed {
    logic [SQ_W-1:0]         rx_sq;
    logic [SQ_W-1:0]         ry_sq;
    logic signed [ACC_W-1:0] stop_x_one;
    logic signed [ACC_W-1:0] x_change_one;
    logic signed [ACC_W-1:0] y_change_two;
    logic signed [ACC_W-1:0] stop_y_two;
  } setup_res_t;

endpackage

/* sv/midpoint_ellipse_rasterizer_unit.sv */
// Top level of the midpoint ellipse rasterizer: handshake, walk state and output register.
// Depends on mer_pkg and mer_setup.
//
// Usage. Items arrive as beats on the in_ channel; in_tuser says whether a beat starts
// a new ellipse (centre, radii, quadrant mask and mode in in_tdata) or advances to the
// next point. Each start and each advance of a running ellipse gives one beat on the
// out_ channel with the mirrored x and y coordinates and the span length; out_tlast
// marks the final point. An advance while no ellipse runs is taken and gives nothing.
// A start runs through the shared setup multiplier, the load state and the walk
// states STEP_A to STEP_D before its result is registered. An advance runs only the
// walk states, the chain of dependent 40-bit adds and compares of one walk step
// (update, error test, conditional update, region test); in_tready is high again
// as the result appears. The block takes no new beat while it works on one.
// Reset leaves the block idle with no ellipse and an empty output register.
// When the receiver stalls, the finished beat stays in the output register; the
// next item is still taken, and its own result waits until that register is free.
module midpoint_ellipse_rasterizer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // center_x[7:0], center_y[15:8], radius_x[23:16], radius_y[31:24],
  // quadrant_select[35:32], fill_mode[36], zero[39:37]
  input  logic [mer_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // right_x[7:0], left_x[15:8], top_y[23:16], bottom_y[31:24],
  // span_length[40:32], quadrants_out[44:41], zero[47:45]
  output logic [mer_pkg::OUT_DATA_W-1:0]    out_tdata,
  // fill_out[0]
  output logic                              out_tuser,
  output logic                              out_tlast
);

  localparam int unsigned CW = mer_pkg::COORD_W;
  localparam int unsigned AW = mer_pkg::ACC_W;
  localparam int unsigned TW = mer_pkg::TWICE_W;

  mer_pkg::state_t     state_r, state_nxt;
  mer_pkg::phase_t     phase_r, phase_nxt;
  mer_pkg::setup_res_t setup_res;
  logic                setup_done;
  logic                setup_start;

  // Saved start parameters.
  logic [CW-1:0]                 cx_r, cy_r, rx_r, ry_r;
  logic [mer_pkg::QUAD_W-1:0]    quad_r;
  logic                          fill_r;

  // Walk state.
  logic [CW-1:0]         px_r, px_nxt, py_r, py_nxt;
  logic [CW-1:0]         px_hold_r, px_hold_nxt, py_hold_r, py_hold_nxt;
  logic signed [AW-1:0]  err_r, err_nxt, xc_r, xc_nxt, yc_r, yc_nxt;
  logic signed [AW-1:0]  stop_x_r, stop_x_nxt, stop_y_r, stop_y_nxt;
  logic [TW-1:0]         trx_r, trx_nxt, try_r, try_nxt;
  logic                  test_r, test_nxt;
  logic                  last_hold_r, last_hold_nxt;

  logic [AW-1:0]         trx_ext, try_ext;
  logic signed [AW-1:0]  test_sel;
  logic [AW:0]           test_sum;
  logic                  radii_zero;
  logic                  in_accept;
  logic                  do_step_a;
  logic                  load_out;
  logic                  last_now;
  logic                  out_last_src;

  // Output register.
  logic                         out_valid_r;
  logic [mer_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                         out_fill_r;
  logic                         out_last_r;

  logic [CW-1:0]                right_x, left_x, top_y, bottom_y;
  logic [mer_pkg::SPAN_W-1:0]   span_length;

  mer_setup u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (setup_start),
    .radius_x (rx_r),
    .radius_y (ry_r),
    .done     (setup_done),
    .res      (setup_res)
  );

  assign in_tready  = (state_r == mer_pkg::ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign radii_zero = (rx_r == '0) && (ry_r == '0);
  assign trx_ext    = {{(AW-TW){1'b0}}, trx_r};
  assign try_ext    = {{(AW-TW){1'b0}}, try_r};

  // Error test of a walk step: 2 * error + x change (first region) or y change (second region) > 0.
  assign test_sel = (phase_r == mer_pkg::PH_ONE) ? xc_r : yc_r;
  assign test_sum = {err_r, 1'b0} + {test_sel[AW-1], test_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mer_pkg::ST_IDLE;
      phase_r     <= mer_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_tuser == mer_pkg::KIND_START)) begin
      cx_r   <= in_tdata[7:0];
      cy_r   <= in_tdata[15:8];
      rx_r   <= in_tdata[23:16];
      ry_r   <= in_tdata[31:24];
      quad_r <= in_tdata[35:32];
      fill_r <= in_tdata[36];
    end
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    px_hold_r   <= px_hold_nxt;
    py_hold_r   <= py_hold_nxt;
    err_r       <= err_nxt;
    xc_r        <= xc_nxt;
    yc_r        <= yc_nxt;
    stop_x_r    <= stop_x_nxt;
    stop_y_r    <= stop_y_nxt;
    trx_r       <= trx_nxt;
    try_r       <= try_nxt;
    test_r      <= test_nxt;
    last_hold_r <= last_hold_nxt;
    if (load_out) begin
      out_data_r <= out_data_nxt;
      out_fill_r <= fill_r;
      out_last_r <= out_last_src;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    setup_start   = 1'b0;
    do_step_a     = 1'b0;
    load_out      = 1'b0;
    last_now      = 1'b0;
    px_nxt        = px_r;
    py_nxt        = py_r;
    px_hold_nxt   = px_hold_r;
    py_hold_nxt   = py_hold_r;
    err_nxt       = err_r;
    xc_nxt        = xc_r;
    yc_nxt        = yc_r;
    stop_x_nxt    = stop_x_r;
    stop_y_nxt    = stop_y_r;
    trx_nxt       = trx_r;
    try_nxt       = try_r;
    test_nxt      = test_r;
    last_hold_nxt = last_hold_r;

    unique case (state_r)
      mer_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_tuser == mer_pkg::KIND_START) begin
            setup_start = 1'b1;
            state_nxt   = mer_pkg::ST_SETUP;
          end else if (phase_r != mer_pkg::PH_IDLE) begin
            // The first walk cycle runs on the edge that takes the advance beat.
            do_step_a = 1'b1;
            state_nxt = mer_pkg::ST_STEP_B;
          end
        end
      end
      mer_pkg::ST_SETUP: begin
        if (setup_done) begin
          state_nxt = mer_pkg::ST_LOAD;
        end
      end
      mer_pkg::ST_LOAD: begin
        px_nxt     = rx_r;
        py_nxt     = '0;
        xc_nxt     = setup_res.x_change_one;
        yc_nxt     = {{(AW-mer_pkg::SQ_W){1'b0}}, setup_res.rx_sq};
        err_nxt    = '0;
        stop_x_nxt = setup_res.stop_x_one;
        stop_y_nxt = '0;
        trx_nxt    = {1'b0, setup_res.rx_sq, 1'b0};
        try_nxt    = {1'b0, setup_res.ry_sq, 1'b0};
        phase_nxt  = mer_pkg::PH_ONE;
        state_nxt  = mer_pkg::ST_STEP_A;
      end
      mer_pkg::ST_STEP_A: begin
        do_step_a = 1'b1;
        state_nxt = mer_pkg::ST_STEP_B;
      end
      mer_pkg::ST_STEP_B: begin
        test_nxt  = !test_sum[AW] && (test_sum != '0);
        state_nxt = mer_pkg::ST_STEP_C;
      end
      mer_pkg::ST_STEP_C: begin
        if (test_r) begin
          if (phase_r == mer_pkg::PH_ONE) begin
            px_nxt     = px_r - 1'b1;
            stop_x_nxt = stop_x_r - try_ext;
            err_nxt    = err_r + xc_r;
            xc_nxt     = xc_r + try_ext;
          end else begin
            py_nxt     = py_r - 1'b1;
            stop_y_nxt = stop_y_r - trx_ext;
            err_nxt    = err_r + yc_r;
            yc_nxt     = yc_r + trx_ext;
          end
        end
        state_nxt = mer_pkg::ST_STEP_D;
      end
      mer_pkg::ST_STEP_D: begin
        if (phase_r == mer_pkg::PH_ONE) begin
          if (radii_zero || (stop_x_r < stop_y_r)) begin
            // Second region: x from zero up, y from the vertical radius down.
            px_nxt     = '0;
            py_nxt     = ry_r;
            xc_nxt     = {{(AW-mer_pkg::SQ_W){1'b0}}, setup_res.ry_sq};
            yc_nxt     = setup_res.y_change_two;
            err_nxt    = '0;
            stop_x_nxt = '0;
            stop_y_nxt = setup_res.stop_y_two;
            phase_nxt  = mer_pkg::PH_TWO;
          end
        end else if (radii_zero || (stop_x_r > stop_y_r)) begin
          last_now  = 1'b1;
          phase_nxt = mer_pkg::PH_IDLE;
        end
        last_hold_nxt = last_now;
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = mer_pkg::ST_IDLE;
        end else begin
          state_nxt = mer_pkg::ST_EMIT;
        end
      end
      mer_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = mer_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mer_pkg::ST_IDLE;
      end
    endcase

    if (do_step_a) begin
      px_hold_nxt = px_r;
      py_hold_nxt = py_r;
      if (phase_r == mer_pkg::PH_ONE) begin
        py_nxt     = py_r + 1'b1;
        stop_y_nxt = stop_y_r + trx_ext;
        err_nxt    = err_r + yc_r;
        yc_nxt     = yc_r + trx_ext;
      end else begin
        px_nxt     = px_r + 1'b1;
        stop_x_nxt = stop_x_r + try_ext;
        err_nxt    = err_r + xc_r;
        xc_nxt     = xc_r + try_ext;
      end
    end
  end

  assign out_last_src = (state_r == mer_pkg::ST_STEP_D) ? last_now : last_hold_r;

  // Point coordinates mirrored about the centre (in fill mode the bottom y is the centre row); all wrap modulo 256.
  assign right_x     = cx_r + px_hold_r;
  assign left_x      = cx_r - px_hold_r;
  assign top_y       = cy_r - py_hold_r;
  assign bottom_y    = fill_r ? cy_r : (cy_r + py_hold_r);
  assign span_length = {1'b0, py_hold_r} + 9'd1;

  assign out_data_nxt = {3'b000, quad_r, span_length, bottom_y, top_y, left_x, right_x};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fill_r;
  assign out_tlast  = out_last_r;

endmodule

/* sv/mer_setup.sv */
// Setup sequencer: one shared signed multiplier works out the squared radii and
// the start values of both regions in turn. Depends on mer_pkg.
module mer_setup (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [mer_pkg::COORD_W-1:0]     radius_x,
  input  logic [mer_pkg::COORD_W-1:0]     radius_y,
  output logic                            done,
  output mer_pkg::setup_res_t             res
);

  mer_pkg::mul_step_t step_r, step_nxt;

  logic signed [9:0]  mul_a;
  logic signed [16:0] mul_b;
  logic signed [26:0] prod;

  logic [mer_pkg::SQ_W-1:0]         rx_sq_r, ry_sq_r;
  logic signed [mer_pkg::ACC_W-1:0] stop_x_one_r, x_change_one_r;
  logic signed [mer_pkg::ACC_W-1:0] y_change_two_r, stop_y_two_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= mer_pkg::MS_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    step_nxt = step_r;
    mul_a    = '0;
    mul_b    = '0;
    unique case (step_r)
      mer_pkg::MS_IDLE: begin
        if (start) begin
          step_nxt = mer_pkg::MS_RX_SQ;
        end
      end
      mer_pkg::MS_RX_SQ: begin
        mul_a    = $signed({2'b00, radius_x});
        mul_b    = $signed({9'd0, radius_x});
        step_nxt = mer_pkg::MS_RY_SQ;
      end
      mer_pkg::MS_RY_SQ: begin
        mul_a    = $signed({2'b00, radius_y});
        mul_b    = $signed({9'd0, radius_y});
        step_nxt = mer_pkg::MS_STOP_X;
      end
      mer_pkg::MS_STOP_X: begin
        mul_a    = $signed({2'b00, radius_x});
        mul_b    = $signed({1'b0, ry_sq_r});
        step_nxt = mer_pkg::MS_X_CHANGE;
      end
      mer_pkg::MS_X_CHANGE: begin
        // 1 - 2 * rx as a signed factor.
        mul_a    = 10'sd1 - $signed({1'b0, radius_x, 1'b0});
        mul_b    = $signed({1'b0, ry_sq_r});
        step_nxt = mer_pkg::MS_Y_CHANGE;
      end
      mer_pkg::MS_Y_CHANGE: begin
        mul_a    = 10'sd1 - $signed({1'b0, radius_y, 1'b0});
        mul_b    = $signed({1'b0, rx_sq_r});
        step_nxt = mer_pkg::MS_STOP_Y;
      end
      mer_pkg::MS_STOP_Y: begin
        mul_a    = $signed({2'b00, radius_y});
        mul_b    = $signed({1'b0, rx_sq_r});
        step_nxt = mer_pkg::MS_IDLE;
      end
      default: begin
        step_nxt = mer_pkg::MS_IDLE;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    unique case (step_r)
      mer_pkg::MS_RX_SQ:    rx_sq_r        <= prod[mer_pkg::SQ_W-1:0];
      mer_pkg::MS_RY_SQ:    ry_sq_r        <= prod[mer_pkg::SQ_W-1:0];
      mer_pkg::MS_STOP_X:   stop_x_one_r   <= {{12{prod[26]}}, prod, 1'b0};
      mer_pkg::MS_X_CHANGE: x_change_one_r <= {{13{prod[26]}}, prod};
      mer_pkg::MS_Y_CHANGE: y_change_two_r <= {{13{prod[26]}}, prod};
      mer_pkg::MS_STOP_Y:   stop_y_two_r   <= {{12{prod[26]}}, prod, 1'b0};
      default: begin
      end
    endcase
  end

  assign done             = (step_r == mer_pkg::MS_STOP_Y);
  assign res.rx_sq        = rx_sq_r;
  assign res.ry_sq        = ry_sq_r;
  assign res.stop_x_one   = stop_x_one_r;
  assign res.x_change_one = x_change_one_r;
  assign res.y_change_two = y_change_two_r;
  assign res.stop_y_two   = stop_y_two_r;

endmodule
